// ===== rtl/tel_pkg.sv =====
package tel_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 40;
    localparam int VAR_W       = 50;
    localparam int END_W       = 7;
    localparam int HITS_W      = 8;
    localparam int DIV_W       = 32;
    localparam int DVS_W       = 24;
    localparam logic [END_W-1:0] END_SAMPLES_RESET = 7'd6;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    ins;
        logic    pop;
        logic    clr;
        sample_t x;
    } tel_cell_ctl_t;

endpackage

// ===== rtl/tel_cell.sv =====
module tel_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tel_pkg::tel_cell_ctl_t ctl,
    input  tel_pkg::sample_t       left_val,
    input  logic                   left_vld,
    input  logic                   left_gt,
    input  tel_pkg::sample_t       right_val,
    input  logic                   right_vld,
    output tel_pkg::sample_t       val,
    output logic                   vld,
    output logic                   gt
);
    import tel_pkg::*;

    sample_t val_reg;
    logic    vld_reg;

    // an empty cell counts as larger than any sample
    assign gt  = !vld_reg || (val_reg > ctl.x);
    assign val = val_reg;
    assign vld = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.ins && gt)
        begin
            vld_reg <= left_gt ? left_vld : 1'b1;
        end
        else if (ctl.pop)
        begin
            vld_reg <= right_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins && gt)
        begin
            val_reg <= left_gt ? left_val : ctl.x;
        end
        else if (ctl.pop)
        begin
            val_reg <= right_val;
        end
    end

endmodule

// ===== rtl/tel_sorter.sv =====
module tel_sorter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tel_pkg::tel_cell_ctl_t ctl,
    output tel_pkg::sample_t       head_val
);
    import tel_pkg::*;

    sample_t val [MAX_SAMPLES];
    logic    vld [MAX_SAMPLES];
    logic    gt  [MAX_SAMPLES];

    assign head_val = val[0];

    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        sample_t lv;
        logic    lvld;
        logic    lgt;
        sample_t rv;
        logic    rvld;

        if (i == 0)
        begin : g_first
            assign lv   = '0;
            assign lvld = 1'b0;
            assign lgt  = 1'b0;
        end
        else
        begin : g_mid
            assign lv   = val[i-1];
            assign lvld = vld[i-1];
            assign lgt  = gt[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_last
            assign rv   = '0;
            assign rvld = 1'b0;
        end
        else
        begin : g_inner
            assign rv   = val[i+1];
            assign rvld = vld[i+1];
        end

        tel_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_val  (lv),
            .left_vld  (lvld),
            .left_gt   (lgt),
            .right_val (rv),
            .right_vld (rvld),
            .val       (val[i]),
            .vld       (vld[i]),
            .gt        (gt[i])
        );
    end

endmodule

// ===== rtl/tel_div.sv =====
module tel_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tel_pkg::DIV_W-1:0]   dividend,
    input  logic [tel_pkg::DVS_W-1:0]   divisor,
    output logic [tel_pkg::DIV_W-1:0]   quotient,
    output logic                        done
);
    import tel_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DVS_W:0]    rem_sh;
    logic              fits;

    assign rem_sh   = {rem_reg, q_reg[DIV_W-1]};
    assign fits     = rem_sh >= {1'b0, dvs_reg};
    assign quotient = q_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(DIV_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/track_energy_loss_features.sv =====
// Per-track energy-loss summary: median, deviation, truncated sum and mean, end sums.
//
// Input channel: one beat per sample (signed Q8.8), last_sample on the final beat.
// A beat with empty_track set drops anything loaded and yields an all-zero result.
// Samples are taken one per cycle while loading; beyond 256 samples they are dropped.
// Configuration: cfg_wr_en/cfg_wr_data write end_samples (reset value 6).
// Output channel: one beat per track, held in an output register until taken.
// The user writes end_samples only while idle; the block does not enforce it.
// Processing after the last beat, in order:
//   median: shifting the sorting chain out to the middle element
//   variance: states S_VAR1, S_VAR2, S_VAR3; sample pass over the dual-read sample memory
//   32-step divisions on one shared divider: truncated mean, then end ratio if start sum != 0
// An empty-track beat passes straight to the output state, skipping the processing above.
// in_stall is high from the last beat until the result moves to the output register.
// The next track loads while that result waits on out_stall; a further result
// waits inside until the output register empties.
// Reset clears counters, running sums, the sorting chain and the output valid; the sample
// memory is not cleared and needs no pass.
module track_energy_loss_features (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [15:0]             energy_loss_sample,
    input  logic                           last_sample,
    input  logic                           empty_track,
    input  logic                           cfg_wr_en,
    input  logic [tel_pkg::END_W-1:0]      cfg_wr_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [8:0]                     sample_count,
    output logic signed [23:0]             start_sum,
    output logic [15:0]                    end_over_start,
    output logic                           ratio_invalid,
    output logic signed [23:0]             truncated_sum,
    output logic signed [15:0]             truncated_mean,
    output logic                           direction_flipped
);
    import tel_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_MED, S_VAR1, S_VAR2, S_VAR3, S_PASS, S_FLIP,
        S_DIVT_GO, S_DIVT_WAIT, S_DIVR_GO, S_DIVR_WAIT, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [END_W-1:0]        end_samples_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [CNT_W-1:0]        pop_reg;
    sample_t                 med_reg;
    logic [28:0]             plo_reg, phi_reg;
    logic [47:0]             sqs_reg;
    logic [VAR_W-1:0]        lhs_reg, var_reg;
    logic [HITS_W-1:0]       hits_reg, gotf_reg, gotl_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    v0_reg, v1_reg, v2_reg;
    sample_t                 rda_reg, rdb_reg, a1_reg, a2_reg;
    logic [24:0]             t1_reg;
    logic [VAR_W-1:0]        tt2_reg;
    logic signed [SUM_W-1:0] first_reg, lastsum_reg, tsum_reg;
    logic [CNT_W-1:0]        kept_reg;
    logic signed [SUM_W-1:0] s_reg, e_reg;
    logic                    flip_reg, inval_reg;
    logic [15:0]             ratio_reg;
    logic signed [15:0]      tmean_reg;
    logic                    out_vld_reg;
    logic [8:0]              o_cnt_reg;
    logic signed [23:0]      o_s_reg, o_tsum_reg;
    logic [15:0]             o_ratio_reg;
    logic                    o_inval_reg, o_flip_reg;
    logic signed [15:0]      o_tmean_reg;

    sample_t mem [MAX_SAMPLES];

    logic                    accept, store_ok, out_free, half_hit, issue, pass_done;
    logic [CNT_W-1:0]        half;
    logic [CNT_W-1:0]        idx_b;
    logic [SUM_W-1:0]        abs_sum, abs_tsum;
    logic signed [31:0]      x_sq;
    logic signed [16:0]      diff;
    logic [15:0]             absd;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        div_dividend, div_q;
    logic [DVS_W-1:0]        div_divisor;
    tel_cell_ctl_t           cell_ctl;
    sample_t                 head_val;

    assign in_stall  = (state_reg != S_LOAD);
    assign accept    = in_valid && !in_stall;
    assign store_ok  = !empty_track && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign out_free  = !out_vld_reg || !out_stall;
    assign half      = cnt_reg >> 1;
    assign half_hit  = (pop_reg == half);
    assign issue     = (state_reg == S_PASS) && (idx_reg < cnt_reg);
    assign pass_done = (idx_reg == cnt_reg) && !v0_reg && !v1_reg && !v2_reg;
    assign idx_b     = cnt_reg - CNT_W'(1) - idx_reg;
    assign abs_sum   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign abs_tsum  = tsum_reg[SUM_W-1] ? SUM_W'(-tsum_reg) : SUM_W'(tsum_reg);
    assign x_sq      = energy_loss_sample * energy_loss_sample;
    assign diff      = {rda_reg[15], rda_reg} - {med_reg[15], med_reg};
    assign absd      = diff[16] ? 16'(-diff) : diff[15:0];

    assign cell_ctl.ins = accept && store_ok;
    assign cell_ctl.pop = (state_reg == S_MED) && !half_hit;
    assign cell_ctl.clr = (accept && empty_track) || ((state_reg == S_OUT) && out_free);
    assign cell_ctl.x   = energy_loss_sample;

    tel_sorter u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .head_val (head_val)
    );

    assign div_start    = (state_reg == S_DIVT_GO) ||
                          ((state_reg == S_DIVR_GO) && (s_reg != '0));
    assign div_dividend = (state_reg == S_DIVT_GO) ? DIV_W'(abs_tsum)
                                                   : {e_reg[DVS_W-1:0], 8'b0};
    assign div_divisor  = (state_reg == S_DIVT_GO) ? DVS_W'(kept_reg)
                                                   : s_reg[DVS_W-1:0];

    tel_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= energy_loss_sample;
        end
        rda_reg <= mem[idx_reg[ADDR_W-1:0]];
        rdb_reg <= mem[idx_b[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && empty_track)
                begin
                    state_next = S_OUT;
                end
                else if (accept && last_sample)
                begin
                    state_next = S_MED;
                end
            end
            S_MED:       state_next = half_hit ? S_VAR1 : S_MED;
            S_VAR1:      state_next = S_VAR2;
            S_VAR2:      state_next = S_VAR3;
            S_VAR3:      state_next = S_PASS;
            S_PASS:      state_next = pass_done ? S_FLIP : S_PASS;
            S_FLIP:      state_next = S_DIVT_GO;
            S_DIVT_GO:   state_next = S_DIVT_WAIT;
            S_DIVT_WAIT: state_next = div_done ? S_DIVR_GO : S_DIVT_WAIT;
            S_DIVR_GO:   state_next = (s_reg == '0) ? S_OUT : S_DIVR_WAIT;
            S_DIVR_WAIT: state_next = div_done ? S_OUT : S_DIVR_WAIT;
            S_OUT:       state_next = out_free ? S_LOAD : S_OUT;
            default:     state_next = S_LOAD;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            end_samples_reg <= END_SAMPLES_RESET;
            cnt_reg         <= '0;
            sum_reg         <= '0;
            sq_reg          <= '0;
            pop_reg         <= '0;
            idx_reg         <= '0;
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                end_samples_reg <= cfg_wr_data;
            end
            if (accept && empty_track)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end
            else if (accept && store_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + {{(SUM_W-SAMPLE_W){energy_loss_sample[15]}},
                                      energy_loss_sample};
                sq_reg  <= sq_reg + {{(SQ_W-32){1'b0}}, x_sq};
            end
            else if ((state_reg == S_OUT) && out_free)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end
            if (state_reg == S_LOAD)
            begin
                pop_reg <= '0;
                idx_reg <= '0;
            end
            else if (cell_ctl.pop)
            begin
                pop_reg <= pop_reg + 1'b1;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MED && half_hit)
        begin
            med_reg <= head_val;
        end
        if (state_reg == S_VAR1)
        begin
            plo_reg  <= 29'(sq_reg[19:0] * cnt_reg);
            phi_reg  <= 29'(sq_reg[39:20] * cnt_reg);
            sqs_reg  <= 48'(abs_sum * abs_sum);
            hits_reg <= (cnt_reg >= CNT_W'(end_samples_reg)) ? HITS_W'(end_samples_reg)
                                                             : HITS_W'(half);
        end
        if (state_reg == S_VAR2)
        begin
            lhs_reg <= VAR_W'({phi_reg, 20'b0}) + VAR_W'(plo_reg);
        end
        if (state_reg == S_VAR3)
        begin
            var_reg   <= (lhs_reg >= VAR_W'(sqs_reg)) ? lhs_reg - VAR_W'(sqs_reg) : '0;
            gotf_reg  <= '0;
            gotl_reg  <= '0;
            first_reg <= '0;
            lastsum_reg <= '0;
            tsum_reg  <= '0;
            kept_reg  <= '0;
        end
        else
        begin
            if (v0_reg)
            begin
                if (rda_reg > 0 && gotf_reg < hits_reg)
                begin
                    first_reg <= first_reg + SUM_W'(rda_reg);
                    gotf_reg  <= gotf_reg + 1'b1;
                end
                if (rdb_reg > 0 && gotl_reg < hits_reg)
                begin
                    lastsum_reg <= lastsum_reg + SUM_W'(rdb_reg);
                    gotl_reg    <= gotl_reg + 1'b1;
                end
            end
            if (v2_reg && tt2_reg <= var_reg)
            begin
                tsum_reg <= tsum_reg + SUM_W'(a2_reg);
                kept_reg <= kept_reg + 1'b1;
            end
        end
        t1_reg  <= 25'(absd * cnt_reg);
        a1_reg  <= rda_reg;
        tt2_reg <= VAR_W'(t1_reg * t1_reg);
        a2_reg  <= a1_reg;
        if (state_reg == S_FLIP)
        begin
            flip_reg <= lastsum_reg < first_reg;
            s_reg    <= (lastsum_reg < first_reg) ? lastsum_reg : first_reg;
            e_reg    <= (lastsum_reg < first_reg) ? first_reg : lastsum_reg;
        end
        if (state_reg == S_DIVT_WAIT && div_done)
        begin
            tmean_reg <= tsum_reg[SUM_W-1] ? 16'(0 - div_q) : div_q[15:0];
        end
        if (state_reg == S_DIVR_GO)
        begin
            inval_reg <= (s_reg == '0);
            ratio_reg <= '0;
        end
        if (state_reg == S_DIVR_WAIT && div_done)
        begin
            ratio_reg <= (div_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
        end
        if (state_reg == S_LOAD && accept && empty_track)
        begin
            s_reg     <= '0;
            e_reg     <= '0;
            flip_reg  <= 1'b0;
            inval_reg <= 1'b0;
            ratio_reg <= '0;
            tsum_reg  <= '0;
            tmean_reg <= '0;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            o_cnt_reg   <= 9'(cnt_reg);
            o_s_reg     <= s_reg;
            o_ratio_reg <= ratio_reg;
            o_inval_reg <= inval_reg;
            o_tsum_reg  <= tsum_reg;
            o_tmean_reg <= tmean_reg;
            o_flip_reg  <= flip_reg;
        end
    end

    assign out_valid         = out_vld_reg;
    assign sample_count      = o_cnt_reg;
    assign start_sum         = o_s_reg;
    assign end_over_start    = o_ratio_reg;
    assign ratio_invalid     = o_inval_reg;
    assign truncated_sum     = o_tsum_reg;
    assign truncated_mean    = o_tmean_reg;
    assign direction_flipped = o_flip_reg;

endmodule

// ===== rtl/tel_checker.sv =====
module tel_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last_sample,
    input logic               empty_track,
    input logic               out_valid,
    input logic               out_stall,
    input logic [8:0]         sample_count,
    input logic signed [23:0] start_sum,
    input logic [15:0]        end_over_start,
    input logic               ratio_invalid,
    input logic signed [23:0] truncated_sum,
    input logic signed [15:0] truncated_mean,
    input logic               direction_flipped
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_count)
            && $stable(truncated_sum))
    else $error("result beat changed under stall");

    // a closing beat raises in_stall
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (last_sample || empty_track) |=> in_stall)
    else $error("input taken while a track is being finished");

    // a zero count, as from an empty track, comes with all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_count == 9'd0 |-> start_sum == 24'sd0
            && end_over_start == 16'd0 && !ratio_invalid && truncated_sum == 24'sd0
            && truncated_mean == 16'sd0 && !direction_flipped)
    else $error("empty track result not all zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ratio_invalid |-> end_over_start == 16'd0 && start_sum == 24'sd0)
    else $error("invalid ratio with nonzero ratio or start sum");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count <= 9'd256)
    else $error("sample count out of range");

endmodule

bind track_energy_loss_features tel_checker u_tel_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .last_sample       (last_sample),
    .empty_track       (empty_track),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sample_count      (sample_count),
    .start_sum         (start_sum),
    .end_over_start    (end_over_start),
    .ratio_invalid     (ratio_invalid),
    .truncated_sum     (truncated_sum),
    .truncated_mean    (truncated_mean),
    .direction_flipped (direction_flipped)
);
